// ===== design/itcs_pkg.sv =====
// Shared types and constants for the ice thickness continuity stencil.
package itcs_pkg;

    localparam logic [2:0] MASK_GROUNDED   = 3'd1;
    localparam logic [2:0] MASK_OPEN_OCEAN = 3'd7;

    localparam logic [2:0] CFG_LINE_LENGTH   = 3'd0;
    localparam logic [2:0] CFG_LINE_COUNT    = 3'd1;
    localparam logic [2:0] CFG_INCLUDE_MELT  = 3'd2;
    localparam logic [2:0] CFG_OPEN_SEA_ZERO = 3'd3;
    localparam logic [2:0] CFG_MELT_CAP      = 3'd4;

    localparam logic [67:0] PROD_LIMIT = 68'd1 << 58;

    typedef struct packed {
        logic [30:0]        thickness;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] flux_x;
        logic signed [31:0] flux_y;
        logic signed [31:0] accum;
        logic signed [31:0] melt;
        logic [2:0]         mask;
    } cell_t;

    typedef struct packed {
        logic [30:0]        thickness;
        logic signed [31:0] speed_y;
        logic signed [31:0] flux_y;
    } south_t;

    typedef struct packed {
        logic [30:0]        hc;
        logic [30:0]        he;
        logic [30:0]        hw;
        logic [30:0]        hn;
        logic [30:0]        hs;
        logic signed [31:0] uc;
        logic signed [31:0] ue;
        logic signed [31:0] uw;
        logic signed [31:0] vc;
        logic signed [31:0] vn;
        logic signed [31:0] vs;
        logic signed [31:0] fxc;
        logic signed [31:0] fxw;
        logic signed [31:0] fyc;
        logic signed [31:0] fys;
        logic signed [31:0] accum;
        logic signed [31:0] melt;
        logic [2:0]         mask;
        logic               last;
    } window_t;

    typedef struct packed {
        logic        include_melt;
        logic        open_sea_zero;
        logic [30:0] melt_cap;
    } cfg_t;

endpackage

// ===== design/itcs_line_store.sv =====
// Line-delay memories and the five-point stencil window registers.
module itcs_line_store #(
    parameter int MAX_LINE = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         accept,
    input  logic [$clog2(MAX_LINE)-1:0]  col,
    input  itcs_pkg::cell_t              cell_in,
    input  logic                         emit,
    input  logic                         last,
    output logic                         win_valid,
    output itcs_pkg::window_t            win
);
    import itcs_pkg::*;

    localparam int CW = $clog2(MAX_LINE);

    cell_t  mem_a [MAX_LINE];   // one line back
    south_t mem_b [MAX_LINE];   // two lines back

    cell_t   rd_a_reg;
    south_t  rd_b_reg;
    logic    v1_reg, emit1_reg, last1_reg;
    cell_t   cell1_reg;
    logic [CW-1:0] col1_reg;

    cell_t   pe_reg, pc_reg, pw_reg;
    south_t  se_reg, sc_reg;
    cell_t   ne_reg, nc_reg;
    logic    wv_reg, wlast_reg;

    // read-first: a beat written at col reads the previous line's entry
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_a_reg <= mem_a[col];
            rd_b_reg <= mem_b[col];
            if (accept) mem_a[col] <= cell_in;
        end
        if (en && v1_reg) begin
            mem_b[col1_reg] <= '{thickness: rd_a_reg.thickness,
                                 speed_y:   rd_a_reg.speed_y,
                                 flux_y:    rd_a_reg.flux_y};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            wv_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
            wv_reg <= v1_reg && emit1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cell1_reg <= cell_in;
            col1_reg  <= col;
            emit1_reg <= emit;
            last1_reg <= last;
            if (v1_reg) begin
                pe_reg    <= rd_a_reg;
                pc_reg    <= pe_reg;
                pw_reg    <= pc_reg;
                se_reg    <= rd_b_reg;
                sc_reg    <= se_reg;
                ne_reg    <= cell1_reg;
                nc_reg    <= ne_reg;
                wlast_reg <= last1_reg;
            end
        end
    end

    assign win_valid = wv_reg;

    // east taps hold the newest column; north and south centers sit one column back
    always_comb begin
        win.hc    = pc_reg.thickness;
        win.he    = pe_reg.thickness;
        win.hw    = pw_reg.thickness;
        win.hn    = nc_reg.thickness;
        win.hs    = sc_reg.thickness;
        win.uc    = pc_reg.speed_x;
        win.ue    = pe_reg.speed_x;
        win.uw    = pw_reg.speed_x;
        win.vc    = pc_reg.speed_y;
        win.vn    = nc_reg.speed_y;
        win.vs    = sc_reg.speed_y;
        win.fxc   = pc_reg.flux_x;
        win.fxw   = pw_reg.flux_x;
        win.fyc   = pc_reg.flux_y;
        win.fys   = sc_reg.flux_y;
        win.accum = pc_reg.accum;
        win.melt  = pc_reg.melt;
        win.mask  = pc_reg.mask;
        win.last  = wlast_reg;
    end

endmodule

// ===== design/itcs_update.sv =====
// Divergence products, rounding, accumulation, melt and clamp pipeline.
module itcs_update #(
    parameter int VALUE_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              win_valid,
    input  itcs_pkg::window_t win,
    input  itcs_pkg::cfg_t    cfg,
    output logic              m_tvalid,
    output logic [31:0]       m_tdata,   // [30:0] new_thickness, [31] zero
    output logic              m_tlast
);
    import itcs_pkg::*;

    localparam longint LIMIT = (VALUE_BITS - 1 >= 31) ? 64'h7fff_ffff
                                                      : (64'sd1 <<< (VALUE_BITS - 1)) - 1;

    // operand stage
    logic signed [34:0] hc_s, he_s, hw_s, hn_s, hs_s, dhx, dhy, dv;
    logic signed [32:0] a_next [4];
    logic signed [34:0] b_next [4];
    logic [3:0]         neg_next;
    logic               sheet;

    logic signed [32:0] a_reg [4];
    logic signed [34:0] b_reg [4];
    logic [3:0]         neg_reg, neg4_reg;
    logic               sh17_reg, sh17_4_reg;
    logic               v3_reg, v4_reg, v5_reg;
    logic [30:0]        hc3_reg, hc4_reg, hc5_reg;
    logic signed [31:0] acc3_reg, acc4_reg, acc5_reg;
    logic signed [31:0] melt3_reg, melt4_reg, m5_reg;
    logic               kill3_reg, kill4_reg, kill5_reg;
    logic               last3_reg, last4_reg, last5_reg;
    logic signed [67:0] prod_reg [4];
    logic signed [61:0] divq_next, divq_reg;
    logic signed [31:0] m_next;
    logic signed [63:0] r;
    logic               tvalid_reg, tlast_reg;
    logic [30:0]        thick_reg;

    always_comb begin
        hc_s  = {4'b0, win.hc};
        he_s  = {4'b0, win.he};
        hw_s  = {4'b0, win.hw};
        hn_s  = {4'b0, win.hn};
        hs_s  = {4'b0, win.hs};
        dhx   = (win.uc < 0) ? he_s - hc_s : hc_s - hw_s;
        dhy   = (win.vc < 0) ? hn_s - hc_s : hc_s - hs_s;
        dv    = 35'(win.ue) - 35'(win.uw) + 35'(win.vn) - 35'(win.vs);
        sheet = (win.mask == MASK_GROUNDED);
        if (sheet) begin
            a_next[0] = 33'(win.fxc); b_next[0] = hc_s + he_s;
            a_next[1] = 33'(win.fxw); b_next[1] = hw_s + hc_s;
            a_next[2] = 33'(win.fyc); b_next[2] = hc_s + hn_s;
            a_next[3] = 33'(win.fys); b_next[3] = hs_s + hc_s;
            neg_next  = 4'b1010;
        end else begin
            a_next[0] = 33'(win.uc);    b_next[0] = dhx;
            a_next[1] = 33'(win.vc);    b_next[1] = dhy;
            a_next[2] = {2'b0, win.hc}; b_next[2] = dv;
            a_next[3] = '0;             b_next[3] = '0;
            neg_next  = 4'b0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            tvalid_reg <= 1'b0;
        end else if (en) begin
            v3_reg     <= win_valid;
            v4_reg     <= v3_reg;
            v5_reg     <= v4_reg;
            tvalid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                a_reg[i]    <= a_next[i];
                b_reg[i]    <= b_next[i];
                prod_reg[i] <= a_reg[i] * b_reg[i];
            end
            neg_reg   <= neg_next;
            sh17_reg  <= sheet;
            hc3_reg   <= win.hc;
            acc3_reg  <= win.accum;
            melt3_reg <= win.melt;
            kill3_reg <= cfg.open_sea_zero && (win.mask == MASK_OPEN_OCEAN);
            last3_reg <= win.last;

            neg4_reg   <= neg_reg;
            sh17_4_reg <= sh17_reg;
            hc4_reg    <= hc3_reg;
            acc4_reg   <= acc3_reg;
            melt4_reg  <= melt3_reg;
            kill4_reg  <= kill3_reg;
            last4_reg  <= last3_reg;

            divq_reg  <= divq_next;
            hc5_reg   <= hc4_reg;
            acc5_reg  <= acc4_reg;
            m5_reg    <= m_next;
            kill5_reg <= kill4_reg;
            last5_reg <= last4_reg;

            thick_reg <= r[30:0];
            tlast_reg <= last5_reg;
        end
    end

    // round half away from zero on the magnitude, saturate at 2^58;
    // lane 2 carries the halved H*div(u) term on the upwind path
    always_comb begin
        logic [67:0]        mag, rs;
        logic signed [61:0] term;
        logic               sgn;
        logic signed [31:0] cap_s;
        divq_next = '0;
        for (int i = 0; i < 4; i++) begin
            mag = prod_reg[i][67] ? 68'(-prod_reg[i]) : 68'(prod_reg[i]);
            rs  = (sh17_4_reg || i == 2) ? (mag + 68'h1_0000) >> 17
                                         : (mag + 68'h8000) >> 16;
            if (rs > PROD_LIMIT) rs = PROD_LIMIT;
            sgn  = prod_reg[i][67] ^ neg4_reg[i];
            term = sgn ? -$signed({3'b0, rs[58:0]}) : $signed({3'b0, rs[58:0]});
            divq_next = divq_next + term;
        end
        cap_s  = $signed({1'b0, cfg.melt_cap});
        m_next = !cfg.include_melt ? 32'sd0 : (melt4_reg > cap_s ? cap_s : melt4_reg);
    end

    always_comb begin
        r = $signed({33'b0, hc5_reg}) + 64'(acc5_reg) - 64'(divq_reg) - 64'(m5_reg);
        if (r < 0) r = '0;
        if (kill5_reg) r = '0;
        if (r > LIMIT) r = LIMIT;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = {1'b0, thick_reg};
    assign m_tlast  = tlast_reg;

endmodule

// ===== design/ice_thickness_continuity_stencil.sv =====
// Top level: configuration, raster counters, handshake and datapath wiring.
// Throughput: one cell beat per cycle; a result waiting on m_tready stalls every stage.
//   Set by the single-read line memories and the four parallel multiply lanes.
// Pipeline: the beat at (line, column) yields the result for cell (line-1, column-1)
//   through two line-memory stages and four arithmetic stages.
// Reset: aresetn low resets counters, valid flags, config; line memories keep data.
module ice_thickness_continuity_stencil #(
    parameter int MAX_LINE   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [30:0] thickness, [62:31] speed_x, [94:63] speed_y, [126:95] flux_speed_x,
    // [158:127] flux_speed_y, [190:159] accumulation_step, [222:191] melt_step
    input  logic [223:0] s_tdata,
    input  logic [2:0]   s_tuser,  // [2:0] mask_code
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // [30:0] new_thickness
    output logic         m_tlast   // last_cell
);
    import itcs_pkg::*;

    localparam int CW  = $clog2(MAX_LINE);
    localparam int LLW = (CW + 1 > 11) ? CW + 1 : 11;

    logic [10:0]   line_length_reg;
    logic [15:0]   line_count_reg;
    cfg_t          cfg_reg;
    logic [CW-1:0] col_reg;
    logic [15:0]   line_reg;

    logic [LLW-1:0] ll_ext, w_eff;
    logic [16:0]    h_eff;
    logic           en, accept, at_last_col, at_last_line, emit, last;
    cell_t          cell_in;
    logic           win_valid;
    window_t        win;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg       <= 11'd1024;
            line_count_reg        <= 16'd3;
            cfg_reg.include_melt  <= 1'b0;
            cfg_reg.open_sea_zero <= 1'b0;
            cfg_reg.melt_cap      <= 31'h7fff_ffff;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LINE_LENGTH:   line_length_reg       <= cfg_data[10:0];
                CFG_LINE_COUNT:    line_count_reg        <= cfg_data[15:0];
                CFG_INCLUDE_MELT:  cfg_reg.include_melt  <= cfg_data[0];
                CFG_OPEN_SEA_ZERO: cfg_reg.open_sea_zero <= cfg_data[0];
                CFG_MELT_CAP:      cfg_reg.melt_cap      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        ll_ext = LLW'(line_length_reg);
        if (ll_ext < LLW'(3))             w_eff = LLW'(3);
        else if (ll_ext > LLW'(MAX_LINE)) w_eff = LLW'(MAX_LINE);
        else                              w_eff = ll_ext;
        h_eff        = (line_count_reg < 16'd3) ? 17'd3 : {1'b0, line_count_reg};
        at_last_col  = (LLW'(col_reg) + LLW'(1)) >= w_eff;
        at_last_line = ({1'b0, line_reg} + 17'd1) >= h_eff;
        emit         = (col_reg >= CW'(2)) && (line_reg >= 16'd2);
        last         = at_last_col && at_last_line;
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_reg  <= '0;
                line_reg <= at_last_line ? 16'd0 : line_reg + 16'd1;
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_comb begin
        cell_in.thickness = s_tdata[30:0];
        cell_in.speed_x   = s_tdata[62:31];
        cell_in.speed_y   = s_tdata[94:63];
        cell_in.flux_x    = s_tdata[126:95];
        cell_in.flux_y    = s_tdata[158:127];
        cell_in.accum     = s_tdata[190:159];
        cell_in.melt      = s_tdata[222:191];
        cell_in.mask      = s_tuser;
    end

    itcs_line_store #(.MAX_LINE(MAX_LINE)) u_line_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .accept    (accept),
        .col       (col_reg),
        .cell_in   (cell_in),
        .emit      (emit),
        .last      (last),
        .win_valid (win_valid),
        .win       (win)
    );

    itcs_update #(.VALUE_BITS(VALUE_BITS)) u_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .win_valid (win_valid),
        .win       (win),
        .cfg       (cfg_reg),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    logic unused_pad;
    assign unused_pad = s_tdata[223];

`ifndef SYNTHESIS
    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && at_last_col |=> col_reg == '0)
        else $error("column counter did not wrap at end of line");
    a_ready: assert property (@(posedge aclk)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last |=> line_reg == 16'd0)
        else $error("line counter did not wrap at end of grid");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule
